### rtl/fqh_pkg.sv
`timescale 1ns / 1ps

package fqh_pkg;

    localparam int CHANNELS    = 16;
    localparam int SAMPLE_BITS = 16;
    localparam int COUNT_BITS  = 16;
    localparam int CH_BITS     = 4;
    localparam int CFG_BITS    = 16;
    localparam int ADDR_BITS   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int CMP_BITS    = (COUNT_BITS > CFG_BITS) ? COUNT_BITS : CFG_BITS;
    localparam int CFG_IDX_BITS = 1;

    localparam logic [CFG_BITS-1:0] TRIGGER_TIME_RESET = CFG_BITS'(10);
    localparam logic [CFG_BITS-1:0] RECOVER_TIME_RESET = CFG_BITS'(10);

    typedef enum logic [CFG_IDX_BITS-1:0] {
        REG_TRIGGER_TIME = 1'b0,
        REG_RECOVER_TIME = 1'b1
    } cfg_reg_t;

    typedef struct packed {
        logic [CH_BITS-1:0]            channel;
        logic signed [SAMPLE_BITS-1:0] sample_value;
        logic signed [SAMPLE_BITS-1:0] trip_level;
        logic signed [SAMPLE_BITS-1:0] release_level;
        logic                          over_direction;
        logic                          channel_enable;
        logic                          warning_kind;
        logic                          external_fault;
    } sample_t;

    typedef struct packed {
        logic [CH_BITS-1:0] out_channel;
        logic               tripped;
        logic               fault_set;
        logic               fault_clear;
    } result_t;

    typedef struct packed {
        logic                  trip_flag;
        logic [COUNT_BITS-1:0] trip_count;
        logic [COUNT_BITS-1:0] release_count;
    } chan_state_t;

endpackage

### rtl/fqh_update.sv
`timescale 1ns / 1ps

module fqh_update (
    input  fqh_pkg::sample_t                  beat,
    input  fqh_pkg::chan_state_t              state_in,
    input  logic [fqh_pkg::CFG_BITS-1:0]      trigger_time,
    input  logic [fqh_pkg::CFG_BITS-1:0]      recover_time,
    output fqh_pkg::chan_state_t              state_out,
    output fqh_pkg::result_t                  result,
    output logic                              write_en
);

    localparam logic [fqh_pkg::COUNT_BITS-1:0] COUNT_MAX = '1;

    logic                              in_range;
    logic                              trips;
    logic                              recovers;
    logic [fqh_pkg::COUNT_BITS-1:0]    trip_inc;
    logic [fqh_pkg::COUNT_BITS-1:0]    rel_inc;
    logic                              trip_met;
    logic                              rel_met;
    logic                              set_ev;
    logic                              clr_ev;

    assign in_range = (32'(beat.channel) < fqh_pkg::CHANNELS);

    assign trips    = beat.over_direction ? (beat.sample_value > beat.trip_level)
                                          : (beat.sample_value < beat.trip_level);
    assign recovers = beat.over_direction ? (beat.sample_value < beat.release_level)
                                          : (beat.sample_value > beat.release_level);

    assign trip_inc = (state_in.trip_count == COUNT_MAX) ? COUNT_MAX
                                                         : state_in.trip_count + 1'b1;
    assign rel_inc  = (state_in.release_count == COUNT_MAX) ? COUNT_MAX
                                                            : state_in.release_count + 1'b1;

    assign trip_met = (fqh_pkg::CMP_BITS'(trip_inc) >= fqh_pkg::CMP_BITS'(trigger_time));
    assign rel_met  = (fqh_pkg::CMP_BITS'(rel_inc) >= fqh_pkg::CMP_BITS'(recover_time));

    always_comb
    begin
        state_out = state_in;
        set_ev    = 1'b0;
        clr_ev    = 1'b0;
        priority if (!beat.channel_enable)
        begin
            if (state_in.trip_count != '0)
            begin
                state_out.trip_count = state_in.trip_count - 1'b1;
            end
            else
            begin
                state_out.release_count = rel_inc;
                if (rel_met)
                begin
                    state_out.trip_flag = 1'b0;
                    clr_ev              = 1'b1;
                end
            end
        end
        else if (!state_in.trip_flag && !beat.external_fault)
        begin
            if (trips)
            begin
                state_out.trip_count = trip_inc;
                if (trip_met)
                begin
                    state_out.trip_flag = 1'b1;
                    set_ev              = 1'b1;
                    if (beat.warning_kind)
                    begin
                        state_out.trip_count = '0;
                    end
                    else
                    begin
                        state_out.release_count = '0;
                    end
                end
            end
            else
            begin
                state_out.trip_count = '0;
            end
        end
        else
        begin
            if (recovers)
            begin
                state_out.release_count = rel_inc;
                if (rel_met)
                begin
                    state_out.trip_flag = 1'b0;
                    clr_ev              = 1'b1;
                    if (beat.warning_kind)
                    begin
                        state_out.release_count = '0;
                    end
                    else
                    begin
                        state_out.trip_count = '0;
                    end
                end
            end
        end
    end

    assign write_en           = in_range;
    assign result.out_channel = beat.channel;
    assign result.tripped     = in_range & state_out.trip_flag;
    assign result.fault_set   = in_range & set_ev;
    assign result.fault_clear = in_range & clr_ev;

endmodule

### rtl/fault_qualifier_with_hysteresis_top.sv
`timescale 1ns / 1ps

// Channel   Valid          Ready          Payload
// sample    sample_valid   sample_ready   sample  (fqh_pkg::sample_t)
// result    result_valid   result_ready   result  (fqh_pkg::result_t)
// config    cfg_write      (none)         cfg_index, cfg_data
//
// One sample beat per cycle while results are taken; results are registered.
// Per-channel state memory is read at acceptance and written as the beat advances;
// a beat on the channel just updated takes the forwarded state instead.
// Reset clears the entry valid bits; an entry never written reads as all zero.
// A held result stalls the update stage, and sample_ready drops only then.

module fault_qualifier_with_hysteresis_top (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 sample_valid,
    output logic                                 sample_ready,
    input  fqh_pkg::sample_t                     sample,
    output logic                                 result_valid,
    input  logic                                 result_ready,
    output fqh_pkg::result_t                     result,
    input  logic                                 cfg_write,
    input  logic [fqh_pkg::CFG_IDX_BITS-1:0]     cfg_index,
    input  logic [fqh_pkg::CFG_BITS-1:0]         cfg_data
);

    fqh_pkg::chan_state_t state_mem [fqh_pkg::CHANNELS];

    logic [fqh_pkg::CFG_BITS-1:0]  trigger_reg, trigger_next;
    logic [fqh_pkg::CFG_BITS-1:0]  recover_reg, recover_next;
    logic [fqh_pkg::CHANNELS-1:0]  entry_valid_reg, entry_valid_next;
    logic                          s1_valid_reg, s1_valid_next;
    logic                          out_valid_reg, out_valid_next;
    logic                          fwd_reg, fwd_next;
    logic                          rd_valid_reg, rd_valid_next;
    fqh_pkg::sample_t              s1_beat_reg, s1_beat_next;
    fqh_pkg::chan_state_t          fwd_state_reg, fwd_state_next;
    fqh_pkg::chan_state_t          rd_state_reg;
    fqh_pkg::result_t              result_reg, result_next;

    logic                            accept;
    logic                            s1_adv;
    logic                            s1_write;
    logic [fqh_pkg::ADDR_BITS-1:0]   rd_addr;
    logic [fqh_pkg::ADDR_BITS-1:0]   s1_addr;
    fqh_pkg::chan_state_t            cur_state;
    fqh_pkg::chan_state_t            upd_state;
    fqh_pkg::result_t                upd_result;
    logic                            upd_write_en;

    assign rd_addr      = fqh_pkg::ADDR_BITS'(sample.channel);
    assign s1_addr      = fqh_pkg::ADDR_BITS'(s1_beat_reg.channel);
    assign s1_adv       = s1_valid_reg && (!out_valid_reg || result_ready);
    assign sample_ready = !s1_valid_reg || s1_adv;
    assign accept       = sample_valid && sample_ready;
    assign s1_write     = s1_adv && upd_write_en;
    assign cur_state    = fwd_reg      ? fwd_state_reg :
                          rd_valid_reg ? rd_state_reg  : '0;

    fqh_update u_update (
        .beat         (s1_beat_reg),
        .state_in     (cur_state),
        .trigger_time (trigger_reg),
        .recover_time (recover_reg),
        .state_out    (upd_state),
        .result       (upd_result),
        .write_en     (upd_write_en)
    );

    always_comb
    begin
        trigger_next = trigger_reg;
        recover_next = recover_reg;
        if (cfg_write)
        begin
            unique case (fqh_pkg::cfg_reg_t'(cfg_index))
                fqh_pkg::REG_TRIGGER_TIME: trigger_next = cfg_data;
                fqh_pkg::REG_RECOVER_TIME: recover_next = cfg_data;
            endcase
        end
    end

    always_comb
    begin
        entry_valid_next = entry_valid_reg;
        if (s1_write)
        begin
            entry_valid_next[s1_addr] = 1'b1;
        end
        s1_valid_next  = accept ? 1'b1 : (s1_adv ? 1'b0 : s1_valid_reg);
        out_valid_next = s1_adv ? 1'b1 : (result_ready ? 1'b0 : out_valid_reg);
        fwd_next       = accept ? (s1_write && (s1_addr == rd_addr)) : fwd_reg;
        rd_valid_next  = accept ? entry_valid_reg[rd_addr] : rd_valid_reg;
        s1_beat_next   = accept ? sample : s1_beat_reg;
        fwd_state_next = accept ? upd_state : fwd_state_reg;
        result_next    = s1_adv ? upd_result : result_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            trigger_reg     <= fqh_pkg::TRIGGER_TIME_RESET;
            recover_reg     <= fqh_pkg::RECOVER_TIME_RESET;
            entry_valid_reg <= '0;
            s1_valid_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
            fwd_reg         <= 1'b0;
            rd_valid_reg    <= 1'b0;
        end
        else
        begin
            trigger_reg     <= trigger_next;
            recover_reg     <= recover_next;
            entry_valid_reg <= entry_valid_next;
            s1_valid_reg    <= s1_valid_next;
            out_valid_reg   <= out_valid_next;
            fwd_reg         <= fwd_next;
            rd_valid_reg    <= rd_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_beat_reg   <= s1_beat_next;
        fwd_state_reg <= fwd_state_next;
        result_reg    <= result_next;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            rd_state_reg <= state_mem[rd_addr];
        end
        if (s1_write)
        begin
            state_mem[s1_addr] <= upd_state;
        end
    end

    assign result_valid = out_valid_reg;
    assign result       = result_reg;

    a_set_clear_excl: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> !(result.fault_set && result.fault_clear))
        else $error("fault_set and fault_clear in one beat");

    a_set_trips: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result.fault_set) |-> result.tripped)
        else $error("fault_set without trip flag");

    a_clear_untrips: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result.fault_clear) |-> !result.tripped)
        else $error("fault_clear with trip flag still set");

    a_ready_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid_reg |-> sample_ready)
        else $error("sample stalled with empty output register");

endmodule
